>>> sv/swkc_pkg.sv
// Shared types and constants for the sliding window key counter.
// Used by every module of the block; depends on nothing else.
package swkc_pkg;

   // Fixed field widths of the two channels and the control register.
   localparam int KEY_W     = 14;
   localparam int COUNT_W   = 15;
   localparam int WINDOW_W  = 15;

   // The count table covers every value a key field can take.
   localparam int KEY_SPACE = 1 << KEY_W;

   // Default ring depth, and the control register value after reset.
   localparam int MAX_WINDOW_DEFAULT = 16384;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(16384);

   // Depth of the command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   // One classified command as handed from the front to the back.
   typedef struct packed {
      op_type           op;
      logic [KEY_W-1:0] key;
      logic             evicted;
      logic [KEY_W-1:0] evicted_key;
   } cmd_type;

endpackage

>>> sv/swkc_queue.sv
// Short command queue between the front and the back of the key counter.
// Depends on swkc_pkg for the command type and the queue depth.
module swkc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  swkc_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output swkc_pkg::cmd_type pop_data,
   output logic              empty
);

   localparam int DEPTH = swkc_pkg::QUEUE_DEPTH;
   localparam int PTR_W = swkc_pkg::QUEUE_PTR_W;
   localparam int CNT_W = $clog2(DEPTH + 1);

   swkc_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

>>> sv/swkc_front.sv
// Front of the key counter: control register, key ring and eviction decision.
// Depends on swkc_pkg; feeds classified commands into swkc_queue.
module swkc_front #(
   parameter int MAX_WINDOW = swkc_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [swkc_pkg::WINDOW_W-1:0] csr_write_data,
   input  logic                          push,
   input  logic                          op,
   input  logic [swkc_pkg::KEY_W-1:0]    key,
   input  logic                          clearing,
   output logic                          full,
   output logic                          q_push,
   output swkc_pkg::cmd_type             q_data,
   input  logic                          q_full
);

   localparam int KEY_W  = swkc_pkg::KEY_W;
   localparam int WIN_W  = swkc_pkg::WINDOW_W;
   localparam int PTR_W  = $clog2(MAX_WINDOW);
   localparam int OCC_W  = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W  = ((OCC_W > WIN_W) ? OCC_W : WIN_W) + 1;

   logic [WIN_W-1:0] window_ff;
   logic [PTR_W-1:0] oldest_ff, oldest_in;
   logic [PTR_W-1:0] newest_ff, newest_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             s1_valid_ff, s1_valid_in;
   swkc_pkg::op_type s1_op_ff;
   logic [KEY_W-1:0] s1_key_ff;
   logic             s1_evicted_ff;

   logic [KEY_W-1:0] ring_mem [MAX_WINDOW];
   logic [KEY_W-1:0] ring_rd_ff;

   logic             accept;
   logic             is_insert;
   logic             evict;
   logic [CMP_W-1:0] eff_window;

   assign full      = clearing || (s1_valid_ff && q_full);
   assign accept    = push && !full;
   assign is_insert = (swkc_pkg::op_type'(op) == swkc_pkg::OP_INSERT);

   // A window of zero behaves as one; anything beyond the ring depth is clamped.
   always_comb begin
      eff_window = CMP_W'(window_ff);
      if (window_ff == '0) begin
         eff_window = CMP_W'(1);
      end
      if (eff_window > CMP_W'(MAX_WINDOW)) begin
         eff_window = CMP_W'(MAX_WINDOW);
      end
   end

   // The window is at least one wide, so a full window is never empty.
   assign evict = is_insert && (CMP_W'(occ_ff) >= eff_window);

   always_comb begin
      oldest_in   = oldest_ff;
      newest_in   = newest_ff;
      occ_in      = occ_ff;
      s1_valid_in = s1_valid_ff && q_full;
      if (accept) begin
         s1_valid_in = 1'b1;
         if (is_insert) begin
            newest_in = (newest_ff == PTR_W'(MAX_WINDOW - 1)) ? '0
                                                              : newest_ff + PTR_W'(1);
            if (evict) begin
               oldest_in = (oldest_ff == PTR_W'(MAX_WINDOW - 1)) ? '0
                                                                 : oldest_ff + PTR_W'(1);
            end else begin
               occ_in = occ_ff + OCC_W'(1);
            end
         end
      end
   end

   // Read and write in one clock: a full ring hands out the old entry first.
   always_ff @(posedge clock) begin
      if (accept && evict) begin
         ring_rd_ff <= ring_mem[oldest_ff];
      end
      if (accept && is_insert) begin
         ring_mem[newest_ff] <= key;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff      <= swkc_pkg::op_type'(op);
         s1_key_ff     <= key;
         s1_evicted_ff <= evict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= swkc_pkg::WINDOW_RESET;
         oldest_ff   <= '0;
         newest_ff   <= '0;
         occ_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            window_ff <= csr_write_data;
         end
         oldest_ff   <= oldest_in;
         newest_ff   <= newest_in;
         occ_ff      <= occ_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   assign q_push             = s1_valid_ff;
   assign q_data.op          = s1_op_ff;
   assign q_data.key         = s1_key_ff;
   assign q_data.evicted     = s1_evicted_ff;
   assign q_data.evicted_key = s1_evicted_ff ? ring_rd_ff : '0;

endmodule

>>> sv/swkc_back.sv
// Back of the key counter: count table, its clearing pass and the result register.
// Depends on swkc_pkg; takes commands from swkc_queue.
module swkc_back #(
   parameter int MAX_WINDOW = swkc_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  swkc_pkg::cmd_type            q_data,
   output logic                         q_pop,
   output logic                         clearing,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [swkc_pkg::COUNT_W-1:0] rsp_key_count,
   output logic                         rsp_evicted,
   output logic [swkc_pkg::KEY_W-1:0]   rsp_evicted_key
);

   localparam int KEY_W = swkc_pkg::KEY_W;
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_EVICT,
      ST_RESPOND
   } state_type;

   state_type         state_ff, state_in;
   swkc_pkg::cmd_type cmd_ff, cmd_in;
   logic [CNT_W-1:0]  res_ff, res_in;
   logic [KEY_W-1:0]  clr_ff, clr_in;
   logic              out_valid_ff, out_valid_in;
   logic [CNT_W-1:0]  out_count_ff, out_count_in;
   logic              out_evicted_ff, out_evicted_in;
   logic [KEY_W-1:0]  out_ev_key_ff, out_ev_key_in;

   logic [CNT_W-1:0]  count_mem [swkc_pkg::KEY_SPACE];
   logic [CNT_W-1:0]  mem_rd_ff;
   logic              mem_we;
   logic [KEY_W-1:0]  mem_waddr;
   logic [CNT_W-1:0]  mem_wdata;
   logic              mem_re;
   logic [KEY_W-1:0]  mem_raddr;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      res_in         = res_ff;
      clr_in         = clr_ff;
      out_valid_in   = out_valid_ff && !rsp_pop;
      out_count_in   = out_count_ff;
      out_evicted_in = out_evicted_ff;
      out_ev_key_in  = out_ev_key_ff;
      q_pop          = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = cmd_ff.key;
      mem_wdata      = '0;
      mem_re         = 1'b0;
      mem_raddr      = cmd_ff.key;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + KEY_W'(1);
            if (clr_ff == KEY_W'(swkc_pkg::KEY_SPACE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               cmd_in    = q_data;
               mem_re    = 1'b1;
               mem_raddr = q_data.key;
               state_in  = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // Evicting the key just inserted leaves its count as it was.
            if (cmd_ff.op == swkc_pkg::OP_QUERY ||
                (cmd_ff.evicted && cmd_ff.evicted_key == cmd_ff.key)) begin
               res_in   = mem_rd_ff;
               state_in = ST_RESPOND;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = mem_rd_ff + CNT_W'(1);
               res_in    = mem_rd_ff + CNT_W'(1);
               if (cmd_ff.evicted) begin
                  mem_re    = 1'b1;
                  mem_raddr = cmd_ff.evicted_key;
                  state_in  = ST_EVICT;
               end else begin
                  state_in = ST_RESPOND;
               end
            end
         end
         ST_EVICT: begin
            mem_we    = 1'b1;
            mem_waddr = cmd_ff.evicted_key;
            mem_wdata = (mem_rd_ff != '0) ? mem_rd_ff - CNT_W'(1) : mem_rd_ff;
            state_in  = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in   = 1'b1;
               out_count_in   = res_ff;
               out_evicted_in = cmd_ff.evicted;
               out_ev_key_in  = cmd_ff.evicted_key;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_ff <= count_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff         <= cmd_in;
      res_ff         <= res_in;
      out_count_ff   <= out_count_in;
      out_evicted_ff <= out_evicted_in;
      out_ev_key_ff  <= out_ev_key_in;
   end

   assign clearing        = (state_ff == ST_CLEAR);
   assign rsp_empty       = !out_valid_ff;
   assign rsp_key_count   = swkc_pkg::COUNT_W'(out_count_ff);
   assign rsp_evicted     = out_evicted_ff;
   assign rsp_evicted_key = out_ev_key_ff;

endmodule

>>> sv/sliding_window_key_counter.sv
// Top level of the sliding window key counter: front, command queue and back.
// Depends on swkc_pkg, swkc_front, swkc_queue and swkc_back.
//
//   Channel   Ports                                    Moves one word when
//   --------  ---------------------------------------  ----------------------
//   request   push, full, req_op, req_key              push high, full low
//   response  empty, pop, rsp_key_count, rsp_evicted,  pop high, empty low
//             rsp_evicted_key
//   control   csr_write_enable, csr_write_data         csr_write_enable high
//
// After reset the back sweeps the count table to zero, one entry a cycle, and
// full stays high during that pass.
// A request word is registered in the front (ring access) before it enters the
// queue; the back reads a table entry before writing it, so it steps through
// lookup and respond, plus an evict step for an insert that evicts another key.
// A full queue stalls the front, and a response word left unpopped stalls the back.

module sliding_window_key_counter #(
   // Depth of the key ring: the largest window that can be kept.
   parameter int MAX_WINDOW = swkc_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [swkc_pkg::WINDOW_W-1:0] csr_write_data,
   input  logic                          push,
   output logic                          full,
   input  logic                          req_op,
   input  logic [swkc_pkg::KEY_W-1:0]    req_key,
   output logic                          empty,
   input  logic                          pop,
   output logic [swkc_pkg::COUNT_W-1:0]  rsp_key_count,
   output logic                          rsp_evicted,
   output logic [swkc_pkg::KEY_W-1:0]    rsp_evicted_key
);

   // Commands leave the front already classified: the eviction decision and
   // the evicted key come from the ring, so the back only touches counts.
   swkc_pkg::cmd_type front_cmd;
   swkc_pkg::cmd_type back_cmd;
   logic              front_push;
   logic              queue_full;
   logic              queue_empty;
   logic              back_pop;
   logic              clearing;

   // The front owns the window size register, the key ring and its pointers.
   swkc_front #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push             (push),
      .op               (req_op),
      .key              (req_key),
      .clearing         (clearing),
      .full             (full),
      .q_push           (front_push),
      .q_data           (front_cmd),
      .q_full           (queue_full)
   );

   // A two-word queue lets the front and the back stall independently.
   swkc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_cmd),
      .full      (queue_full),
      .pop       (back_pop),
      .pop_data  (back_cmd),
      .empty     (queue_empty)
   );

   // The back owns the count table, its clearing pass and the response register.
   swkc_back #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (queue_empty),
      .q_data          (back_cmd),
      .q_pop           (back_pop),
      .clearing        (clearing),
      .rsp_empty       (empty),
      .rsp_pop         (pop),
      .rsp_key_count   (rsp_key_count),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key)
   );

endmodule
